// ----- src/crt_pkg.sv -----
// Shared types, constants and codes for the congruence combiner.
package crt_pkg;

    localparam int MODULUS_WIDTH_DEF  = 32;
    localparam int COMBINED_WIDTH_DEF = 64;
    localparam int RES_W = 63;
    localparam int MOD_W = 31;
    localparam int IN_W  = 32;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic                    start_system;
        logic signed [IN_W-1:0]  residue;
        logic [MOD_W-1:0]        modulus;
    } t_in_item;

    typedef struct packed {
        logic [RES_W-1:0] combined_residue;
        logic [RES_W-1:0] combined_modulus;
        logic             no_solution;
        logic             overflow;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NONE   = 5'd0,
        OP_LOAD   = 5'd1,
        OP_START  = 5'd2,
        OP_BMODM  = 5'd3,
        OP_EUCL   = 5'd4,
        OP_AMODD  = 5'd5,
        OP_BMODD  = 5'd6,
        OP_SETINC = 5'd7,
        OP_MDIVD  = 5'd8,
        OP_MULOV  = 5'd9,
        OP_SETOVF = 5'd10,
        OP_AMODM  = 5'd11,
        OP_DIFFD  = 5'd12,
        OP_COEF   = 5'd13,
        OP_MULK   = 5'd14,
        OP_KMOD   = 5'd15,
        OP_MULR   = 5'd16
    } t_op;

    typedef struct packed {
        logic go;
        t_op  op;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic start;
        logic flagged;
        logic r1_zero;
        logic cons;
        logic ovc;
    } t_status;

endpackage

// ----- src/crt_stream_if.sv -----
// Valid/ready stream channel carrying one beat of payload.
interface crt_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/crt_ctrl.sv -----
// Sequencer that steps the shared divide/multiply datapath through one merge.
module crt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  crt_pkg::t_status i_st,
    input  logic            i_out_free,
    output logic            o_in_ready,
    output crt_pkg::t_cmd   o_cmd
);
    import crt_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_LOAD  = 16'h0002,
        ST_START = 16'h0004,
        ST_BMODM = 16'h0008,
        ST_EUCL  = 16'h0010,
        ST_AMODD = 16'h0020,
        ST_BMODD = 16'h0040,
        ST_MDIVD = 16'h0080,
        ST_MULOV = 16'h0100,
        ST_AMODM = 16'h0200,
        ST_DIFFD = 16'h0400,
        ST_COEF  = 16'h0800,
        ST_MULK  = 16'h1000,
        ST_KMOD  = 16'h2000,
        ST_MULR  = 16'h4000,
        ST_PUSH  = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_issued, n_issued;
    logic   l_eng;
    t_op    l_op;
    t_state l_next;

    always_comb begin
        n_state    = r_state;
        n_issued   = r_issued;
        o_cmd      = '{go: 1'b0, op: OP_NONE, push: 1'b0};
        o_in_ready = 1'b0;
        l_eng      = 1'b0;
        l_op       = OP_NONE;
        l_next     = ST_IDLE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd    = '{go: 1'b1, op: OP_LOAD, push: 1'b0};
                    n_state  = ST_LOAD;
                    n_issued = 1'b1;
                end
            end
            ST_LOAD: begin
                if (i_st.done) begin
                    n_state  = ST_START;
                    n_issued = 1'b0;
                end
            end
            ST_START: begin
                if (i_st.start) begin
                    o_cmd   = '{go: 1'b1, op: OP_START, push: 1'b0};
                    n_state = ST_PUSH;
                end else if (i_st.flagged) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_BMODM;
                end
            end
            ST_BMODM: begin
                l_eng = 1'b1; l_op = OP_BMODM; l_next = ST_EUCL;
            end
            ST_EUCL: begin
                if (!r_issued && i_st.r1_zero) begin
                    n_state = ST_AMODD;
                end else begin
                    l_eng = 1'b1; l_op = OP_EUCL; l_next = ST_EUCL;
                end
            end
            ST_AMODD: begin
                l_eng = 1'b1; l_op = OP_AMODD; l_next = ST_BMODD;
            end
            ST_BMODD: begin
                l_eng = 1'b1; l_op = OP_BMODD; l_next = ST_MDIVD;
            end
            ST_MDIVD: begin
                if (!r_issued && !i_st.cons) begin
                    o_cmd   = '{go: 1'b1, op: OP_SETINC, push: 1'b0};
                    n_state = ST_PUSH;
                end else begin
                    l_eng = 1'b1; l_op = OP_MDIVD; l_next = ST_MULOV;
                end
            end
            ST_MULOV: begin
                l_eng = 1'b1; l_op = OP_MULOV; l_next = ST_AMODM;
            end
            ST_AMODM: begin
                if (!r_issued && i_st.ovc) begin
                    o_cmd   = '{go: 1'b1, op: OP_SETOVF, push: 1'b0};
                    n_state = ST_PUSH;
                end else begin
                    l_eng = 1'b1; l_op = OP_AMODM; l_next = ST_DIFFD;
                end
            end
            ST_DIFFD: begin
                l_eng = 1'b1; l_op = OP_DIFFD; l_next = ST_COEF;
            end
            ST_COEF: begin
                l_eng = 1'b1; l_op = OP_COEF; l_next = ST_MULK;
            end
            ST_MULK: begin
                l_eng = 1'b1; l_op = OP_MULK; l_next = ST_KMOD;
            end
            ST_KMOD: begin
                l_eng = 1'b1; l_op = OP_KMOD; l_next = ST_MULR;
            end
            ST_MULR: begin
                l_eng = 1'b1; l_op = OP_MULR; l_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_out_free) begin
                    o_cmd   = '{go: 1'b0, op: OP_NONE, push: 1'b1};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state  = ST_IDLE;
                n_issued = 1'b0;
            end
        endcase
        if (l_eng) begin
            if (!r_issued) begin
                o_cmd    = '{go: 1'b1, op: l_op, push: 1'b0};
                n_issued = 1'b1;
            end else if (i_st.done) begin
                n_state  = l_next;
                n_issued = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.done |-> r_issued)
        else $error("datapath finished an operation that was not launched");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_out_free && !o_cmd.go)
        else $error("result pushed into an occupied output stage");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");
`endif
endmodule

// ----- src/crt_dpath.sv -----
// Datapath: running system, Euclid registers and a shared radix-2 divide/multiply unit.
module crt_dpath #(
    parameter int MODULUS_WIDTH  = crt_pkg::MODULUS_WIDTH_DEF,
    parameter int COMBINED_WIDTH = crt_pkg::COMBINED_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  crt_pkg::t_cmd             i_cmd,
    input  crt_pkg::t_in_item         i_item,
    output crt_pkg::t_status          o_st,
    output logic [crt_pkg::RES_W-1:0] o_rr,
    output logic [crt_pkg::RES_W-1:0] o_rm,
    output logic                      o_inc,
    output logic                      o_ovf
);
    import crt_pkg::*;

    localparam logic [32:0] MOD_MASK33 = (33'd1 << MODULUS_WIDTH) - 33'd1;
    localparam logic [63:0] LIMIT = (64'd1 << (COMBINED_WIDTH - 1)) - 64'd1;

    logic             r_busy, r_wb, r_mul;
    logic [CNT_W-1:0] r_cnt;
    t_op              r_op;
    logic [63:0]      r_dsh;
    logic [31:0]      r_rem, r_quo, r_div;
    logic signed [63:0] r_acc, r_s0, r_s1;
    logic [62:0]      r_mc;
    logic [94:0]      r_prod;
    logic [MOD_W-1:0] r_m, r_b;
    logic             r_neg, r_start;
    logic [31:0]      r_r0, r_r1, r_t1, r_mq, r_diff, r_inv, r_k;
    logic [63:0]      r_t64;
    logic             r_cons, r_ovc;
    logic [62:0]      r_newm, r_rr, r_rm;
    logic             r_inc, r_ovf;

    logic [MOD_W-1:0] w_mraw, w_m;
    logic [31:0]      w_vabs;
    logic [32:0]      w_rsh, w_sub;
    logic             w_ge;
    logic [63:0]      w_s0abs;
    logic [32:0]      w_dsum, w_dsub;
    logic [63:0]      n_dvd;
    logic [31:0]      n_div, n_mpl;
    logic [62:0]      n_mc;
    logic             n_wide, n_mul, n_isdiv;

    assign w_mraw  = i_item.modulus & MOD_MASK33[MOD_W-1:0];
    assign w_m     = (w_mraw == '0) ? MOD_W'(1) : w_mraw;
    assign w_vabs  = i_item.residue[IN_W-1] ? 32'(-i_item.residue) : 32'(i_item.residue);
    assign w_rsh   = {r_rem, r_dsh[63]};
    assign w_sub   = w_rsh - {1'b0, r_div};
    assign w_ge    = (w_rsh >= {1'b0, r_div});
    assign w_s0abs = r_s0[63] ? 64'(-r_s0) : 64'(r_s0);
    assign w_dsum  = {2'b00, r_b} + {2'b00, r_m} - {1'b0, r_rem};
    assign w_dsub  = w_dsum - {2'b00, r_m};

    always_comb begin
        n_dvd = '0; n_div = 32'd1; n_mc = '0; n_mpl = '0;
        n_wide = 1'b0; n_mul = 1'b0; n_isdiv = 1'b0;
        case (i_cmd.op)
            OP_LOAD:  begin n_isdiv = 1'b1; n_dvd = {32'd0, w_vabs}; n_div = {1'b0, w_m}; end
            OP_BMODM: begin
                n_isdiv = 1'b1; n_wide = 1'b1; n_dvd = {1'b0, r_rm}; n_div = {1'b0, r_m};
            end
            OP_EUCL:  begin n_isdiv = 1'b1; n_dvd = {32'd0, r_r0}; n_div = r_r1; end
            OP_AMODD: begin n_isdiv = 1'b1; n_wide = 1'b1; n_dvd = {1'b0, r_rr}; n_div = r_r0; end
            OP_BMODD: begin n_isdiv = 1'b1; n_dvd = {33'd0, r_b}; n_div = r_r0; end
            OP_MDIVD: begin n_isdiv = 1'b1; n_dvd = {33'd0, r_m}; n_div = r_r0; end
            OP_MULOV: begin n_mul = 1'b1; n_mc = r_rm; n_mpl = r_mq; end
            OP_AMODM: begin
                n_isdiv = 1'b1; n_wide = 1'b1; n_dvd = {1'b0, r_rr}; n_div = {1'b0, r_m};
            end
            OP_DIFFD: begin n_isdiv = 1'b1; n_dvd = {32'd0, r_diff}; n_div = r_r0; end
            OP_COEF:  begin n_isdiv = 1'b1; n_dvd = {32'd0, w_s0abs[31:0]}; n_div = r_mq; end
            OP_MULK:  begin n_mul = 1'b1; n_mc = {31'd0, r_t1}; n_mpl = r_inv; end
            OP_KMOD:  begin n_isdiv = 1'b1; n_wide = 1'b1; n_dvd = r_t64; n_div = r_mq; end
            OP_MULR:  begin n_mul = 1'b1; n_mc = r_rm; n_mpl = r_k; end
            default:  begin n_dvd = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_wb   <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_NONE;
            r_rr   <= '0;
            r_rm   <= 63'd1;
            r_inc  <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_wb <= 1'b0;
            if (i_cmd.go) begin
                r_op <= i_cmd.op;
                case (i_cmd.op)
                    OP_START: begin
                        r_rr  <= {32'd0, r_b};
                        r_rm  <= {32'd0, r_m};
                        r_inc <= 1'b0;
                        r_ovf <= ({33'd0, r_m} > LIMIT);
                    end
                    OP_SETINC: r_inc <= 1'b1;
                    OP_SETOVF: r_ovf <= 1'b1;
                    default: begin
                        r_busy <= 1'b1;
                        r_mul  <= n_mul;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_acc  <= '0;
                        r_prod <= '0;
                        r_div  <= n_div;
                        r_mc   <= n_mc;
                        if (n_mul) begin
                            r_dsh <= {n_mpl, 32'd0};
                            r_cnt <= CNT_W'(32);
                        end else if (n_wide) begin
                            r_dsh <= n_dvd;
                            r_cnt <= CNT_W'(64);
                        end else begin
                            r_dsh <= {n_dvd[31:0], 32'd0};
                            r_cnt <= CNT_W'(32);
                        end
                    end
                endcase
                if (i_cmd.op == OP_LOAD) begin
                    r_m     <= w_m;
                    r_neg   <= i_item.residue[IN_W-1];
                    r_start <= i_item.start_system;
                end
            end else if (r_busy) begin
                r_dsh <= {r_dsh[62:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_mul) begin
                    r_prod <= {r_prod[93:0], 1'b0} + (r_dsh[63] ? {32'd0, r_mc} : 95'd0);
                end else begin
                    r_rem <= w_ge ? w_sub[31:0] : w_rsh[31:0];
                    r_quo <= {r_quo[30:0], w_ge};
                    r_acc <= (r_acc <<< 1) + (w_ge ? r_s1 : 64'sd0);
                end
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_wb   <= 1'b1;
                end
            end else if (r_wb) begin
                case (r_op)
                    OP_LOAD:
                        r_b <= (r_neg && r_rem != '0) ? (r_m - r_rem[MOD_W-1:0]) : r_rem[MOD_W-1:0];
                    OP_BMODM: begin
                        r_r0 <= r_rem;
                        r_r1 <= {1'b0, r_m};
                        r_s0 <= 64'sd1;
                        r_s1 <= 64'sd0;
                    end
                    OP_EUCL: begin
                        r_r0 <= r_r1;
                        r_r1 <= r_rem;
                        r_s0 <= r_s1;
                        r_s1 <= r_s0 - r_acc;
                    end
                    OP_AMODD: r_t1 <= r_rem;
                    OP_BMODD: r_cons <= (r_rem == r_t1);
                    OP_MDIVD: r_mq <= r_quo;
                    OP_MULOV: begin
                        r_newm <= r_prod[62:0];
                        r_ovc  <= (r_prod > {31'd0, LIMIT});
                    end
                    OP_AMODM: r_diff <= (w_dsum >= {2'b00, r_m}) ? w_dsub[31:0] : w_dsum[31:0];
                    OP_DIFFD: r_t1 <= r_quo;
                    OP_COEF:  r_inv <= (r_s0[63] && r_rem != '0) ? (r_mq - r_rem) : r_rem;
                    OP_MULK:  r_t64 <= r_prod[63:0];
                    OP_KMOD:  r_k <= r_rem;
                    OP_MULR: begin
                        r_rr <= r_rr + r_prod[62:0];
                        r_rm <= r_newm;
                    end
                    default: r_t1 <= r_t1;
                endcase
            end
        end
    end

    assign o_st = '{done: r_wb, start: r_start, flagged: r_inc | r_ovf,
                    r1_zero: (r_r1 == '0), cons: r_cons, ovc: r_ovc};
    assign o_rr  = r_rr;
    assign o_rm  = r_rm;
    assign o_inc = r_inc;
    assign o_ovf = r_ovf;

`ifndef NO_ASSERTIONS
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |-> !r_busy && !r_wb)
        else $error("operation launched while the unit is busy");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.go && n_isdiv) |-> n_div != '0)
        else $error("division launched with a zero divisor");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("unit busy with an exhausted step count");
`endif
endmodule

// ----- src/crt_congruence_combiner_core.sv -----
// Generalized CRT combiner: one congruence in, running solution and sticky flags out.
// A start item or an already flagged system skips the merge; a merge runs the Euclid
//   loop and the divide and multiply steps on 31-bit moduli, and an output stall holds
//   the result back. Every divide and multiply step runs on one shared radix-2 unit.
// Throughput: one item at a time; the next item is taken once the result sits in the
//   output register. Reset: synchronous; system x == 0 (mod 1), flags clear.
module crt_congruence_combiner_core #(
    parameter int MODULUS_WIDTH  = crt_pkg::MODULUS_WIDTH_DEF,
    parameter int COMBINED_WIDTH = crt_pkg::COMBINED_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crt_stream_if.sink   i_cong,
    crt_stream_if.source o_comb
);
    import crt_pkg::*;

    t_cmd             w_cmd;
    t_status          w_st;
    logic             w_in_ready, w_out_free;
    logic [RES_W-1:0] w_rr, w_rm;
    logic             w_inc, w_ovf;
    logic             r_ovalid;
    t_out_item        r_out;

    crt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cong.valid),
        .i_st       (w_st),
        .i_out_free (w_out_free),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    crt_dpath #(
        .MODULUS_WIDTH  (MODULUS_WIDTH),
        .COMBINED_WIDTH (COMBINED_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_cong.payload),
        .o_st    (w_st),
        .o_rr    (w_rr),
        .o_rm    (w_rm),
        .o_inc   (w_inc),
        .o_ovf   (w_ovf)
    );

    assign i_cong.ready = w_in_ready;
    assign w_out_free   = !r_ovalid || o_comb.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (o_comb.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.push) begin
            r_out <= '{combined_residue: w_rr, combined_modulus: w_rm,
                       no_solution: w_inc, overflow: w_ovf};
        end
    end

    assign o_comb.valid   = r_ovalid;
    assign o_comb.payload = r_out;
endmodule

// ----- test/tb.sv -----
// Self-checking bench for the congruence combiner: directed, random and stall tests.
module tb;
    import crt_pkg::*;

    localparam longint unsigned CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG = 20000;

    logic i_clk;
    logic i_rst_n;

    crt_stream_if #(.t_payload(t_in_item))  cong_if ();
    crt_stream_if #(.t_payload(t_out_item)) comb_if ();

    crt_congruence_combiner_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cong (cong_if.sink),
        .o_comb (comb_if.source)
    );

    longint unsigned sys_res;
    longint unsigned sys_mod;
    bit              sys_inc;
    bit              sys_ovf;

    t_out_item solution_q[$];
    int  mismatches;
    int  beats_in;
    int  beats_out;
    int  idle_cycles;
    bit  rx_idle_en;
    bit  tx_idle_en;
    int  hold_off;
    bit  hold_req;
    bit  hold_seen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned norm_res(logic signed [31:0] raw,
                                                 longint unsigned m);
        longint v;
        longint r;
        v = raw;
        r = v % longint'(m);
        if (r < 0) r += longint'(m);
        return longint'(r);
    endfunction

    function automatic longint unsigned bezout(longint unsigned a, longint unsigned b,
                                               output longint coef);
        longint r0;
        longint r1;
        longint s0;
        longint s1;
        longint q;
        longint t;
        r0 = a; r1 = b; s0 = 1; s1 = 0;
        while (r1 != 0) begin
            q = r0 / r1;
            t = r0 - q * r1; r0 = r1; r1 = t;
            t = s0 - q * s1; s0 = s1; s1 = t;
        end
        coef = s0;
        return r0;
    endfunction

    function automatic t_out_item solve_cong(t_in_item it);
        longint unsigned m;
        longint unsigned r;
        longint unsigned d;
        longint unsigned mq;
        longint unsigned diff;
        longint          coef;
        longint          cm;
        t_out_item       o;
        m = it.modulus;
        if (m == 0) m = 1;
        r = norm_res(it.residue, m);
        if (it.start_system) begin
            sys_inc = 1'b0;
            sys_ovf = (m > CAP);
            sys_res = r;
            sys_mod = m;
        end else if (!sys_inc && !sys_ovf) begin
            d = bezout(sys_mod % m, m, coef);
            if ((sys_res % d) != (r % d)) begin
                sys_inc = 1'b1;
            end else begin
                mq = m / d;
                if (mq > CAP / sys_mod) begin
                    sys_ovf = 1'b1;
                end else begin
                    diff = (r + m - (sys_res % m)) % m;
                    cm = coef % longint'(mq);
                    if (cm < 0) cm += longint'(mq);
                    sys_res = sys_res + sys_mod * (((diff / d) * longint'(cm)) % mq);
                    sys_mod = sys_mod * mq;
                end
            end
        end
        o.combined_residue = sys_res[62:0];
        o.combined_modulus = sys_mod[62:0];
        o.no_solution      = sys_inc;
        o.overflow         = sys_ovf;
        return o;
    endfunction

    task automatic send_cong(bit st, logic signed [31:0] res, logic [30:0] m);
        t_in_item it;
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            cong_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.start_system = st;
        it.residue      = res;
        it.modulus      = m;
        cong_if.payload <= it;
        cong_if.valid   <= 1'b1;
        @(posedge i_clk);
        while (!cong_if.ready) @(posedge i_clk);
        solution_q.push_back(solve_cong(it));
        beats_in++;
    endtask

    task automatic drain_results();
        cong_if.valid <= 1'b0;
        while (solution_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [30:0] rand_mod();
        case ($urandom_range(0, 4))
            0: return 31'($urandom_range(1, 64));
            1: return 31'($urandom_range(1, 4096));
            2: return 31'($urandom_range(1, 1 << 20));
            3: return 31'($urandom);
            default: return 31'($urandom_range(2, 1000) * $urandom_range(1, 30));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            comb_if.ready <= 1'b0;
            hold_off      <= 0;
            hold_seen     <= hold_req;
        end else if (hold_seen != hold_req) begin
            comb_if.ready <= 1'b0;
            hold_off      <= 299;
            hold_seen     <= hold_req;
        end else if (hold_off > 0) begin
            comb_if.ready <= 1'b0;
            hold_off      <= hold_off - 1;
        end else if (rx_idle_en && comb_if.ready && $urandom_range(0, 5) == 0) begin
            comb_if.ready <= 1'b0;
            hold_off      <= $urandom_range(0, 13);
        end else begin
            comb_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_o;
        t_out_item got;
        if (!i_rst_n) begin
            mismatches = 0;
            beats_out  = 0;
        end else if (comb_if.valid && comb_if.ready) begin
            got = comb_if.payload;
            beats_out++;
            if (solution_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
                exp_o = solution_q.pop_front();
                if (got.combined_residue != exp_o.combined_residue ||
                    got.combined_modulus != exp_o.combined_modulus ||
                    got.no_solution != exp_o.no_solution ||
                    got.overflow != exp_o.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d %0b%0b got %0d/%0d %0b%0b",
                                 exp_o.combined_residue, exp_o.combined_modulus,
                                 exp_o.no_solution, exp_o.overflow,
                                 got.combined_residue, got.combined_modulus,
                                 got.no_solution, got.overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            idle_cycles <= 0;
        else if ((cong_if.valid && cong_if.ready) || (comb_if.valid && comb_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        send_cong(1'b0, 32'sd7, 31'd5);
        send_cong(1'b0, 32'sd3, 31'd7);
        send_cong(1'b0, -32'sd1, 31'd0);
        send_cong(1'b1, 32'sh8000_0000, 31'h7FFF_FFFF);
        send_cong(1'b1, 32'sh7FFF_FFFF, 31'd1);
        send_cong(1'b1, 32'sd2, 31'd6);
        send_cong(1'b0, 32'sd4, 31'd8);
        send_cong(1'b0, 32'sd1, 31'd9);
        send_cong(1'b0, 32'sd3, 31'd4);
        send_cong(1'b0, 32'sd5, 31'd7);
        send_cong(1'b1, -32'sd5, 31'd12);
        send_cong(1'b0, 32'sd4, 31'd18);
        send_cong(1'b1, 32'sd1, 31'h7FFF_FFFF);
        send_cong(1'b0, 32'sd2, 31'h7FFF_FFFE);
        send_cong(1'b0, 32'sd3, 31'h7FFF_FFFD);
        send_cong(1'b0, 32'sd4, 31'h7FFF_FFFB);
        send_cong(1'b0, 32'sd5, 31'd11);
        send_cong(1'b1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        send_cong(1'b0, 32'sh8000_0000, 31'd0);
        send_cong(1'b0, -32'sd1, 31'h4000_0000);
    endtask

    task automatic test_random(int n);
        longint unsigned x;
        logic [30:0] m;
        int len;
        int i;
        i = 0;
        while (i < n) begin
            len = $urandom_range(1, 6);
            x = {$urandom, $urandom};
            for (int k = 0; k < len && i < n; k++) begin
                m = rand_mod();
                if (m == 0) m = 1;
                if ($urandom_range(0, 4) != 0)
                    send_cong(k == 0, 32'(norm_res(32'(x), 64'(m)))
                              - ($urandom_range(0, 1) ? 32'(m) : 32'd0), m);
                else
                    send_cong($urandom_range(0, 7) == 0, 32'($urandom), m);
                i++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = ~hold_req;
        repeat (6) send_cong(1'b1, 32'($urandom), rand_mod());
        drain_results();
        send_cong(1'b1, 32'sd9, 31'd10);
    endtask

    initial begin
        i_rst_n = 1'b0;
        cong_if.valid = 1'b0;
        cong_if.payload = '0;
        sys_res = 0; sys_mod = 1; sys_inc = 0; sys_ovf = 0;
        beats_in = 0;
        rx_idle_en = 1'b1; tx_idle_en = 1'b1; hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(780);
        rx_idle_en = 1'b0; tx_idle_en = 1'b0;
        test_random(150);
        drain_results();
        $display("covered %0d congruences, %0d results: starts, merges, zero moduli,",
                 beats_in, beats_out);
        $display("inconsistency, lcm overflow, sticky flags and long output stalls");
        if (mismatches == 0 && solution_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
